// ===== rtl/lsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants for the LED strip pattern pixel generator.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int MAX_PIXELS = 1024;

  localparam int IDX_W   = 10;
  localparam int STEP_W  = 11;
  localparam int PH_W    = 2;
  localparam int CNT_W   = 11;
  localparam int COLOR_W = 24;
  localparam int MODE_W  = 3;
  localparam int POS_W   = 8;
  localparam int CFG_IDX_W = 2;

  // rainbow cycle position = index * 256 / count, one quotient bit per divide step
  localparam int QUO_W               = POS_W;
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES          = QUO_W / DIV_STEPS_PER_STAGE;
  // decode stage, divide stages, color/output stage
  localparam int NSTAGE              = DIV_STAGES + 2;

  localparam logic [CNT_W-1:0] MAX_PIXELS_C = CNT_W'(MAX_PIXELS);

  typedef enum logic [MODE_W-1:0] {
    MODE_FILL       = 3'd0,
    MODE_PERCENT    = 3'd1,
    MODE_WIPE       = 3'd2,
    MODE_RAINBOW    = 3'd3,
    MODE_CYCLE      = 3'd4,
    MODE_CHASE      = 3'd5,
    MODE_CHASE_RB   = 3'd6
  } lsp_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 2'd0,
    REG_FILL_COLOR  = 2'd1,
    REG_PIXEL_COUNT = 2'd2,
    REG_LIT_COUNT   = 2'd3
  } lsp_reg_e;

  // effective configuration: counts already capped
  typedef struct packed {
    lsp_mode_e          mode;
    logic [COLOR_W-1:0] fill_color;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   lit;
  } lsp_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] step8;
    logic             in_range;
    logic             lit_ok;
    logic             wipe_ok;
    logic             match3;
    logic [POS_W-1:0] wpos;
    logic [CNT_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } lsp_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               we;
    logic [IDX_W-1:0]   idx;
  } lsp_out_t;

endpackage

// ===== rtl/lsp_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_decode
// Front stage: range checks, chase phase match and wheel positions.
// ----------------------------------------------------------------------------
module lsp_decode (
  input  lsp_pkg::lsp_cfg_t               cfg_i,
  input  logic [lsp_pkg::IDX_W-1:0]       pixel_index_i,
  input  logic [lsp_pkg::STEP_W-1:0]      frame_step_i,
  input  logic [lsp_pkg::PH_W-1:0]        phase_i,
  output lsp_pkg::lsp_item_t              item_o
);

  localparam logic [8:0] MOD255 = 9'd255;

  // 4^k = 1 mod 3, so sum the base-4 digits
  function automatic logic [1:0] mod3(input logic [lsp_pkg::IDX_W-1:0] v);
    logic [3:0] s;
    s = 4'({2'b00, v[1:0]}) + 4'({2'b00, v[3:2]}) + 4'({2'b00, v[5:4]})
      + 4'({2'b00, v[7:6]}) + 4'({2'b00, v[9:8]});
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: mod3 = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       mod3 = 2'd1;
      default:                              mod3 = 2'd2;
    endcase
  endfunction

  logic [lsp_pkg::CNT_W-1:0] idx_w;
  logic [lsp_pkg::CNT_W:0]   cr_sum;
  logic [8:0]                cr_fold;
  logic [lsp_pkg::POS_W-1:0] cr_pos;
  logic [lsp_pkg::STEP_W-1:0] rb_sum;

  assign idx_w = {1'b0, pixel_index_i};

  // chase rainbow: ((idx - phase) + step) mod 255, 256 = 1 mod 255
  assign cr_sum  = {2'b00, pixel_index_i} - {10'd0, phase_i} + {1'b0, frame_step_i};
  assign cr_fold = {5'd0, cr_sum[11:8]} + {1'b0, cr_sum[7:0]};
  assign cr_pos  = (cr_fold >= MOD255) ? 8'(cr_fold - MOD255) : cr_fold[7:0];

  assign rb_sum  = idx_w + frame_step_i;

  always_comb begin
    item_o.idx      = pixel_index_i;
    item_o.step8    = frame_step_i[lsp_pkg::POS_W-1:0];
    item_o.in_range = idx_w < cfg_i.count;
    item_o.lit_ok   = idx_w < cfg_i.lit;
    item_o.wipe_ok  = idx_w <= frame_step_i;
    item_o.match3   = {1'b0, mod3(pixel_index_i)} == phase_i;
    item_o.wpos     = (cfg_i.mode == lsp_pkg::MODE_CHASE_RB) ? cr_pos
                                                             : rb_sum[lsp_pkg::POS_W-1:0];
    // idx < count, so the partial remainder starts at idx
    item_o.rem      = idx_w;
    item_o.quo      = '0;
  end

endmodule

// ===== rtl/lsp_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_div_stage
// Restoring divide steps for index * 256 / count, DIV_STEPS_PER_STAGE quotient bits a stage.
// ----------------------------------------------------------------------------
module lsp_div_stage (
  input  lsp_pkg::lsp_item_t         item_i,
  input  logic [lsp_pkg::CNT_W-1:0]  count_i,
  output lsp_pkg::lsp_item_t         item_o
);

  always_comb begin
    logic [lsp_pkg::CNT_W:0] r2;
    item_o = item_i;
    for (int s = 0; s < lsp_pkg::DIV_STEPS_PER_STAGE; s++) begin
      r2 = {item_o.rem, 1'b0};
      if (r2 >= {1'b0, count_i}) begin
        r2 = r2 - {1'b0, count_i};
        item_o.quo = {item_o.quo[lsp_pkg::QUO_W-2:0], 1'b1};
      end else begin
        item_o.quo = {item_o.quo[lsp_pkg::QUO_W-2:0], 1'b0};
      end
      item_o.rem = r2[lsp_pkg::CNT_W-1:0];
    end
  end

endmodule

// ===== rtl/lsp_color.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_color
// Back stage: wheel lookup and per-mode color / write flag selection.
// ----------------------------------------------------------------------------
module lsp_color (
  input  lsp_pkg::lsp_cfg_t   cfg_i,
  input  lsp_pkg::lsp_item_t  item_i,
  output lsp_pkg::lsp_out_t   pix_o
);

  localparam logic [7:0] SEG1 = 8'd85;
  localparam logic [7:0] SEG2 = 8'd170;
  localparam logic [7:0] FULL = 8'd255;

  // three-segment wheel on the reversed position
  function automatic logic [23:0] wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] q;
    logic [9:0] t3;
    logic [7:0] u;
    logic [7:0] v;
    p = ~pos;
    if (p < SEG1) begin
      q = p;
    end else if (p < SEG2) begin
      q = p - SEG1;
    end else begin
      q = p - SEG2;
    end
    t3 = {2'b00, q} + {1'b0, q, 1'b0};
    u  = t3[7:0];
    v  = FULL - u;
    if (p < SEG1) begin
      wheel = {v, 8'h00, u};
    end else if (p < SEG2) begin
      wheel = {8'h00, u, v};
    end else begin
      wheel = {u, v, 8'h00};
    end
  endfunction

  logic [lsp_pkg::POS_W-1:0]   pos;
  logic [lsp_pkg::COLOR_W-1:0] wcol;

  assign pos  = (cfg_i.mode == lsp_pkg::MODE_CYCLE) ? (item_i.quo + item_i.step8)
                                                    : item_i.wpos;
  assign wcol = wheel(pos);

  always_comb begin
    logic                       we;
    logic [lsp_pkg::COLOR_W-1:0] c;
    we = 1'b0;
    c  = '0;
    case (cfg_i.mode)
      lsp_pkg::MODE_FILL: begin
        we = 1'b1;
        c  = cfg_i.fill_color;
      end
      lsp_pkg::MODE_PERCENT: begin
        we = item_i.lit_ok;
        c  = cfg_i.fill_color;
      end
      lsp_pkg::MODE_WIPE: begin
        we = item_i.wipe_ok;
        c  = cfg_i.fill_color;
      end
      lsp_pkg::MODE_RAINBOW, lsp_pkg::MODE_CYCLE: begin
        we = 1'b1;
        c  = wcol;
      end
      lsp_pkg::MODE_CHASE: begin
        we = 1'b1;
        c  = item_i.match3 ? cfg_i.fill_color : '0;
      end
      lsp_pkg::MODE_CHASE_RB: begin
        we = 1'b1;
        c  = item_i.match3 ? wcol : '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
    we        = we & item_i.in_range;
    pix_o.we    = we;
    pix_o.color = we ? c : '0;
    pix_o.idx   = item_i.idx;
  end

endmodule

// ===== rtl/led_strip_pattern_pixel_generator.sv =====
`timescale 1ns / 1ps
// Pipeline: an accepted request moves through the decode register, four divide
//   stages of two quotient bits each and the color/output register.
// Throughput: one pixel per cycle unless out_ready_i stalls; divide stages set depth.
// Reset: mode rainbow, fill color 0, pixel count 1024, lit count 0, pipeline empty.
// ----------------------------------------------------------------------------
// led_strip_pattern_pixel_generator
// Per-pixel LED strip color generator: fill, percent, wipe, rainbow, cycle and chase modes.
// ----------------------------------------------------------------------------
module led_strip_pattern_pixel_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lsp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lsp_pkg::COLOR_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lsp_pkg::IDX_W-1:0]         pixel_index_i,
  input  logic [lsp_pkg::STEP_W-1:0]        frame_step_i,
  input  logic [lsp_pkg::PH_W-1:0]          phase_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lsp_pkg::COLOR_W-1:0]       pixel_color_o,
  output logic                              write_enable_o,
  output logic [lsp_pkg::IDX_W-1:0]         index_echo_o
);

  localparam int NS = lsp_pkg::NSTAGE;
  localparam int ND = lsp_pkg::DIV_STAGES;

  lsp_pkg::lsp_mode_e          mode_q;
  logic [lsp_pkg::COLOR_W-1:0] fill_q;
  logic [lsp_pkg::CNT_W-1:0]   count_q;
  logic [lsp_pkg::CNT_W-1:0]   lit_q;
  lsp_pkg::lsp_cfg_t           cfg;
  logic [lsp_pkg::CNT_W-1:0]   n_eff;

  logic [NS-1:0]               v_q;
  logic [NS:0]                 adv;
  lsp_pkg::lsp_item_t          st_q   [ND+1];
  lsp_pkg::lsp_item_t          div_out[ND];
  lsp_pkg::lsp_item_t          dec_item;
  lsp_pkg::lsp_out_t           pix_d;
  lsp_pkg::lsp_out_t           out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lsp_pkg::MODE_RAINBOW;
      fill_q  <= '0;
      count_q <= lsp_pkg::MAX_PIXELS_C;
      lit_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lsp_pkg::REG_MODE:        mode_q  <= lsp_pkg::lsp_mode_e'(cfg_data_i[lsp_pkg::MODE_W-1:0]);
        lsp_pkg::REG_FILL_COLOR:  fill_q  <= cfg_data_i;
        lsp_pkg::REG_PIXEL_COUNT: count_q <= cfg_data_i[lsp_pkg::CNT_W-1:0];
        lsp_pkg::REG_LIT_COUNT:   lit_q   <= cfg_data_i[lsp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (count_q < lsp_pkg::MAX_PIXELS_C) ? count_q : lsp_pkg::MAX_PIXELS_C;

  always_comb begin
    cfg.mode       = mode_q;
    cfg.fill_color = fill_q;
    cfg.count      = n_eff;
    cfg.lit        = (lit_q < n_eff) ? lit_q : n_eff;
  end

  // a stage advances when it is empty or the stage after it advances
  always_comb begin
    adv[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  lsp_decode u_decode (
    .cfg_i         (cfg),
    .pixel_index_i (pixel_index_i),
    .frame_step_i  (frame_step_i),
    .phase_i       (phase_i),
    .item_o        (dec_item)
  );

  for (genvar g = 0; g < ND; g++) begin : g_div
    lsp_div_stage u_div (
      .item_i  (st_q[g]),
      .count_i (n_eff),
      .item_o  (div_out[g])
    );
  end

  lsp_color u_color (
    .cfg_i  (cfg),
    .item_i (st_q[ND]),
    .pix_o  (pix_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      st_q[0] <= dec_item;
    end
    for (int k = 1; k <= ND; k++) begin
      if (adv[k]) begin
        st_q[k] <= div_out[k-1];
      end
    end
    if (adv[NS-1]) begin
      out_q <= pix_d;
    end
  end

  assign out_valid_o    = v_q[NS-1];
  assign pixel_color_o  = out_q.color;
  assign write_enable_o = out_q.we;
  assign index_echo_o   = out_q.idx;

  // back-pressure only comes from a full pipe with a blocked output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

  // skipped pixels carry no color
  a_no_write_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_enable_o) |-> (pixel_color_o == '0))
    else $error("color present on a pixel that is not written");

  // a request leaving decode lands in the first divide stage
  a_decode_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && adv[1]) |=> v_q[1])
    else $error("request lost between decode and divide");

  // an accepted request always enters the pipe
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted request not captured");

endmodule

// ===== test/tb_led_strip_pattern_pixel_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_strip_pattern_pixel_generator
// Drives pixel requests through the pattern generator under a sequence of
// register settings (every mode code, strip lengths from zero to above the
// cap, lit counts past the strip end) and checks every returned color, write
// flag and echoed index against an in-bench color-wheel predictor. Both
// handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_led_strip_pattern_pixel_generator;
  import lsp_pkg::*;

  localparam int N_MODES     = 8;
  localparam int N_PHASES    = 21;
  localparam int PHASE_ITEMS = 50;
  localparam int SETTLE      = 8;     // a little past the pipeline depth
  localparam int WDOG_LIMIT  = 2000;

  class pixel_scoreboard;
    logic [MODE_W-1:0]  mode;
    logic [COLOR_W-1:0] fill_color;
    logic [CNT_W-1:0]   pixel_count;
    logic [CNT_W-1:0]   lit_count;
    lsp_out_t           color_q[$];
    int                 errors;
    int                 requests;
    int                 written;

    function new();
      mode        = MODE_RAINBOW;
      fill_color  = '0;
      pixel_count = MAX_PIXELS_C;
      lit_count   = '0;
      errors      = 0;
      requests    = 0;
      written     = 0;
    endfunction

    function void set_reg(lsp_reg_e r, logic [COLOR_W-1:0] d);
      case (r)
        REG_MODE:        mode        = d[MODE_W-1:0];
        REG_FILL_COLOR:  fill_color  = d;
        REG_PIXEL_COUNT: pixel_count = d[CNT_W-1:0];
        REG_LIT_COUNT:   lit_count   = d[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int strip_len();
      return (int'(pixel_count) < MAX_PIXELS) ? int'(pixel_count) : MAX_PIXELS;
    endfunction

    // three-segment wheel on the reversed position
    function logic [COLOR_W-1:0] wheel_rgb(int pos);
      int p;
      p = 255 - (pos & 255);
      if (p < 85) return {8'(255 - p * 3), 8'd0, 8'(p * 3)};
      if (p < 170) begin
        p = p - 85;
        return {8'd0, 8'(p * 3), 8'(255 - p * 3)};
      end
      p = p - 170;
      return {8'(p * 3), 8'(255 - p * 3), 8'd0};
    endfunction

    function lsp_out_t predict_pixel(logic [IDX_W-1:0] idx, logic [STEP_W-1:0] step,
                                     logic [PH_W-1:0] ph);
      lsp_out_t r;
      int       n;
      int       lit;
      int       i;
      int       s;
      n = strip_len();
      i = int'(idx);
      s = int'(step);
      r.color = '0;
      r.we    = 1'b0;
      r.idx   = idx;
      if (i < n) begin
        case (mode)
          MODE_FILL: begin
            r.color = fill_color;
            r.we    = 1'b1;
          end
          MODE_PERCENT: begin
            lit = (int'(lit_count) < n) ? int'(lit_count) : n;
            if (i < lit) begin
              r.color = fill_color;
              r.we    = 1'b1;
            end
          end
          MODE_WIPE: begin
            if (i <= s) begin
              r.color = fill_color;
              r.we    = 1'b1;
            end
          end
          MODE_RAINBOW: begin
            r.color = wheel_rgb((i + s) & 255);
            r.we    = 1'b1;
          end
          MODE_CYCLE: begin
            r.color = wheel_rgb(((i * 256) / n + s) & 255);
            r.we    = 1'b1;
          end
          MODE_CHASE: begin
            r.we = 1'b1;
            if (i % 3 == int'(ph)) r.color = fill_color;
          end
          MODE_CHASE_RB: begin
            r.we = 1'b1;
            if (i % 3 == int'(ph)) r.color = wheel_rgb(((i - int'(ph)) + s) % 255);
          end
          default: ;
        endcase
      end
      return r;
    endfunction

    function void note_request(logic [IDX_W-1:0] idx, logic [STEP_W-1:0] step,
                               logic [PH_W-1:0] ph);
      lsp_out_t r;
      r = predict_pixel(idx, step, ph);
      color_q.push_back(r);
      requests++;
      if (r.we) written++;
    endfunction

    function void check_result(logic [COLOR_W-1:0] color, logic we, logic [IDX_W-1:0] idx);
      lsp_out_t e;
      if (color_q.size() == 0) begin
        $display("%0t: unexpected result color %h we %b idx %0d", $time, color, we, idx);
        errors++;
        return;
      end
      e = color_q.pop_front();
      if (idx !== e.idx) begin
        $display("%0t: index_echo expected %0d got %0d", $time, e.idx, idx);
        errors++;
      end
      if (we !== e.we) begin
        $display("%0t: write_enable idx %0d expected %b got %b", $time, e.idx, e.we, we);
        errors++;
      end
      if (color !== e.color) begin
        $display("%0t: pixel_color idx %0d expected %h got %h", $time, e.idx, e.color, color);
        errors++;
      end
    endfunction

    function int pending();
      return color_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [COLOR_W-1:0]  cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [IDX_W-1:0]    pixel_index_i;
  logic [STEP_W-1:0]   frame_step_i;
  logic [PH_W-1:0]     phase_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [COLOR_W-1:0]  pixel_color_o;
  logic                write_enable_o;
  logic [IDX_W-1:0]    index_echo_o;

  pixel_scoreboard sb = new();
  bit              no_gaps;
  int              settings_applied;
  int              idle_cycles;

  led_strip_pattern_pixel_generator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_index_i (pixel_index_i),
    .frame_step_i  (frame_step_i),
    .phase_i       (phase_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_color_o (pixel_color_o),
    .write_enable_o(write_enable_o),
    .index_echo_o  (index_echo_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_pixel(logic [IDX_W-1:0] idx, logic [STEP_W-1:0] step,
                            logic [PH_W-1:0] ph);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_index_i <= idx;
    frame_step_i  <= step;
    phase_i       <= ph;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(idx, step, ph);
  endtask

  task automatic write_reg(lsp_reg_e r, logic [COLOR_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= d;
    @(posedge clk_i);
    sb.set_reg(r, d);
  endtask

  // only called with the pipeline empty
  task automatic apply_config(logic [MODE_W-1:0] m, logic [COLOR_W-1:0] fill,
                              logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] lit);
    write_reg(REG_MODE, COLOR_W'(m));
    write_reg(REG_FILL_COLOR, fill);
    write_reg(REG_PIXEL_COUNT, COLOR_W'(cnt));
    write_reg(REG_LIT_COUNT, COLOR_W'(lit));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_applied++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return CNT_W'(1);
      2: return MAX_PIXELS_C;
      3: return '1;
      4: return CNT_W'($urandom_range(MAX_PIXELS + 1, 2047));
      5, 6: return CNT_W'($urandom_range(2, 40));
      default: return CNT_W'($urandom_range(1, MAX_PIXELS));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_lit(logic [CNT_W-1:0] cnt);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return cnt;
      2: return '1;
      3: return CNT_W'($urandom_range(0, 2047));
      default: return CNT_W'($urandom_range(0, int'(cnt)));
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] pick_fill();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  task automatic random_phase(int ph_num);
    logic [MODE_W-1:0]  m;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   lit;
    logic [IDX_W-1:0]   idx;
    logic [STEP_W-1:0]  step;
    logic [PH_W-1:0]    ph;
    int                 n;
    int                 s;
    m   = MODE_W'(ph_num % N_MODES);
    cnt = pick_count();
    lit = pick_lit(cnt);
    apply_config(m, pick_fill(), cnt, lit);
    no_gaps = (ph_num % 4 == 3);
    n = sb.strip_len();
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      // mostly pixels on the strip, some anywhere
      if (n > 0 && $urandom_range(0, 99) < 85) idx = IDX_W'($urandom_range(0, n - 1));
      else idx = IDX_W'($urandom_range(0, 1023));
      if (m == MODE_WIPE && $urandom_range(0, 3) != 0) begin
        s = int'(idx) + $urandom_range(0, 6) - 3;
        step = STEP_W'((s < 0) ? 0 : s);
      end else begin
        step = STEP_W'($urandom_range(0, 2047));
      end
      ph = ($urandom_range(0, 9) == 0) ? PH_W'(3) : PH_W'($urandom_range(0, 2));
      send_pixel(idx, step, ph);
    end
    drain();
  endtask

  // result side: segments of always-ready, light, heavy and bursty stalls
  initial begin
    int seg;
    int style;
    int stall_left;
    out_ready_i <= 1'b0;
    stall_left = 0;
    @(posedge clk_i);
    forever begin
      style = $urandom_range(0, 3);
      seg   = $urandom_range(20, 150);
      repeat (seg) begin
        @(posedge clk_i);
        if (stall_left > 0) begin
          out_ready_i <= 1'b0;
          stall_left--;
        end else begin
          case (style)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= ($urandom_range(0, 3) != 0);
            2: out_ready_i <= 1'($urandom_range(0, 1));
            default: begin
              out_ready_i <= 1'b1;
              if ($urandom_range(0, 11) == 0) stall_left = $urandom_range(5, 40);
            end
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(pixel_color_o, write_enable_o, index_echo_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, WDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [IDX_W-1:0]  d_idx  [3];
    logic [STEP_W-1:0] d_step [3];
    logic [PH_W-1:0]   d_ph   [3];
    d_idx  = '{IDX_W'(0), IDX_W'(1023), IDX_W'(7)};
    d_step = '{STEP_W'(0), STEP_W'(2047), STEP_W'(6)};
    d_ph   = '{PH_W'(0), PH_W'(3), PH_W'(1)};
    settings_applied = 0;
    no_gaps          = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_MODE;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    pixel_index_i <= '0;
    frame_step_i  <= '0;
    phase_i       <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: rainbow over the full strip
    send_pixel(IDX_W'(1023), STEP_W'(2047), PH_W'(0));
    send_pixel(IDX_W'(0), STEP_W'(0), PH_W'(2));
    drain();

    // every mode code on a short strip, off-strip index and phase three included
    for (int m = 0; m < N_MODES; m++) begin
      apply_config(MODE_W'(m), '1, CNT_W'(12), CNT_W'(5));
      for (int k = 0; k < 3; k++) send_pixel(d_idx[k], d_step[k], d_ph[k]);
      drain();
    end

    for (int p = 0; p < N_PHASES; p++) random_phase(p);

    $display("Covered %0d pixel requests under %0d register settings, all mode codes,",
             sb.requests, settings_applied);
    $display("strip lengths from zero past the cap; %0d results written, %0d skipped.",
             sb.written, sb.requests - sb.written);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== led_strip_pattern_pixel_generator.f =====
rtl/lsp_pkg.sv
rtl/lsp_decode.sv
rtl/lsp_div_stage.sv
rtl/lsp_color.sv
rtl/led_strip_pattern_pixel_generator.sv
test/tb_led_strip_pattern_pixel_generator.sv
